FILE: rtl/pdh_pkg.sv
`timescale 1ns / 1ps

package pdh_pkg;

    // Default widths for the top-level parameters.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int DISTANCE_BITS_DEF = 16;

    // Fixed-point layout: the average carries 16 fraction bits, the factors 12.
    localparam int AVG_FRAC_BITS    = 16;
    localparam int FACTOR_FRAC_BITS = 12;

    // Configuration port.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_DATA_W-1:0] RISE_FACTOR_RST = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] FALL_FACTOR_RST = 16'd2048;
    localparam logic [CFG_DATA_W-1:0] AVG_WEIGHT_RST  = 16'd655;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RISE_FACTOR = 2'd0,
        CFG_FALL_FACTOR = 2'd1,
        CFG_AVG_WEIGHT  = 2'd2
    } cfg_idx_t;

    // Result fields.
    localparam int BACK_W  = 16;
    localparam int LEVEL_W = 16;
    localparam int M_TDATA_W = BACK_W + LEVEL_W;

    typedef struct packed {
        logic               found;
        logic [BACK_W-1:0]  back;
        logic [LEVEL_W-1:0] level;
    } result_t;

    // Outcome of the two threshold tests against the old average.
    typedef struct packed {
        logic above_rise;
        logic above_fall;
    } thresh_flags_t;

endpackage

FILE: rtl/pdh_thresh.sv
`timescale 1ns / 1ps

module pdh_thresh #(
    parameter int SAMPLE_BITS = pdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]                        sample,
    input  logic [SAMPLE_BITS+pdh_pkg::AVG_FRAC_BITS-1:0] avg,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]                factor,
    output logic                                          above
);

    localparam int FRAC  = pdh_pkg::AVG_FRAC_BITS;
    localparam int FW    = pdh_pkg::CFG_DATA_W;
    localparam int BND_W = SAMPLE_BITS + FRAC + 1;
    localparam int HI_W  = SAMPLE_BITS + FW;
    localparam int LO_W  = FRAC + FW;

    logic [SAMPLE_BITS-1:0]    avg_hi;
    logic [FRAC-1:0]           avg_lo;
    logic [HI_W-1:0]           hi_prod;
    logic [LO_W-1:0]           lo_prod;
    logic [BND_W-1:0]          bound;
    logic [BND_W-1:0]          scaled_sample;

    // The bound is avg*factor with the average's fraction truncated away,
    // so comparing against the sample shifted by the factor's fraction is exact.
    assign avg_hi  = avg[SAMPLE_BITS+FRAC-1:FRAC];
    assign avg_lo  = avg[FRAC-1:0];
    assign hi_prod = HI_W'(avg_hi) * HI_W'(factor);
    assign lo_prod = LO_W'(avg_lo) * LO_W'(factor);
    assign bound   = BND_W'(hi_prod) + BND_W'(lo_prod[FRAC+FW-1:FRAC]);

    assign scaled_sample = BND_W'({sample, {pdh_pkg::FACTOR_FRAC_BITS{1'b0}}});
    assign above         = scaled_sample > bound;

endmodule

FILE: rtl/pdh_avg.sv
`timescale 1ns / 1ps

module pdh_avg #(
    parameter int SAMPLE_BITS = pdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          update,
    input  logic [SAMPLE_BITS-1:0]                        sample,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]                weight,
    output logic [SAMPLE_BITS+pdh_pkg::AVG_FRAC_BITS-1:0] avg
);

    localparam int FRAC  = pdh_pkg::AVG_FRAC_BITS;
    localparam int AVG_W = SAMPLE_BITS + FRAC;
    localparam int KEEP_W = FRAC + 1;
    localparam int SUM_W = SAMPLE_BITS + FRAC + 2;
    localparam int HI_W  = SAMPLE_BITS + KEEP_W;
    localparam int LO_W  = FRAC + KEEP_W;

    logic [AVG_W-1:0]                avg_reg;
    logic [AVG_W-1:0]                avg_next;
    logic [KEEP_W-1:0]               keep;
    logic [SAMPLE_BITS+FRAC-1:0]     new_prod;
    logic [HI_W-1:0]                 hi_prod;
    logic [LO_W-1:0]                 lo_prod;
    logic [SUM_W-1:0]                sum;

    // keep = 1.0 - weight in Q0.16, which needs one extra bit for a zero weight.
    assign keep     = (KEEP_W'(1) << FRAC) - KEEP_W'(weight);
    assign new_prod = AVG_W'(weight) * AVG_W'(sample);
    assign hi_prod  = HI_W'(keep) * HI_W'(avg_reg[AVG_W-1:FRAC]);
    assign lo_prod  = LO_W'(keep) * LO_W'(avg_reg[FRAC-1:0]);
    assign sum      = SUM_W'(new_prod) + SUM_W'(hi_prod)
                    + SUM_W'(lo_prod[FRAC+KEEP_W-1:FRAC]);

    // The weighted mean of two values below 2^SAMPLE_BITS always fits.
    assign avg_next = sum[AVG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (update) begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

FILE: rtl/pdh_track.sv
`timescale 1ns / 1ps

module pdh_track #(
    parameter int SAMPLE_BITS   = pdh_pkg::SAMPLE_BITS_DEF,
    parameter int DISTANCE_BITS = pdh_pkg::DISTANCE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   update,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  pdh_pkg::thresh_flags_t flags,
    output pdh_pkg::result_t       res
);

    logic                     tracking_reg;
    logic                     tracking_next;
    logic [SAMPLE_BITS-1:0]   held_reg;
    logic [SAMPLE_BITS-1:0]   held_next;
    logic [DISTANCE_BITS-1:0] since_reg;
    logic [DISTANCE_BITS-1:0] since_next;
    logic [DISTANCE_BITS-1:0] since_inc;
    logic                     found;
    logic                     trk_mid;
    logic [SAMPLE_BITS-1:0]   held_mid;
    logic                     above_half;

    assign since_inc = (&since_reg) ? since_reg : since_reg + DISTANCE_BITS'(1);

    always_comb begin
        trk_mid    = tracking_reg;
        held_mid   = held_reg;
        since_next = since_reg;
        found      = 1'b0;

        if (tracking_reg) begin
            if (sample > held_reg) begin
                held_mid   = sample;
                since_next = '0;
            end else if (flags.above_fall) begin
                since_next = since_inc;
            end else begin
                found   = 1'b1;
                trk_mid = 1'b0;
            end
        end

        // A run that just ended is tested against the start rule with the
        // peak it confirmed, so a fall factor above the rise factor can open a new run at once.
        above_half    = {sample, 1'b0} > {1'b0, held_mid};
        tracking_next = trk_mid;
        held_next     = held_mid;
        if (!trk_mid && flags.above_rise && above_half) begin
            tracking_next = 1'b1;
            held_next     = sample;
            since_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg <= 1'b0;
            held_reg     <= SAMPLE_BITS'(1);
            since_reg    <= '0;
        end else if (update) begin
            tracking_reg <= tracking_next;
            held_reg     <= held_next;
            since_reg    <= since_next;
        end
    end

    assign res.found = found;
    assign res.back  = found ? pdh_pkg::BACK_W'(since_inc) : '0;
    assign res.level = found ? pdh_pkg::LEVEL_W'(held_reg) : pdh_pkg::LEVEL_W'(held_next);

endmodule

FILE: rtl/peak_detector_hysteresis_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                 tuser
// s_        in         sample                             -
// m_        out        peak_back, peak_level              peak_found
// cfg_      in         write: rise, fall, avg_weight      -
//
// One result beat per sample beat; a new sample is taken every cycle while m_tready is high.
// A sample passes through two registers: an input register, then the result register.
// The loop that sets the rate is the running average register, whose update
// and both threshold tests are combinational between those two registers.
// Reset is synchronous on aresetn and clears the average, the run state and
// the configuration to their defaults.
// A stalled m_ side holds the result; the input register still takes one more
// beat, and s_tready drops only when both registers are full.

module peak_detector_hysteresis_unit #(
    parameter int SAMPLE_BITS   = pdh_pkg::SAMPLE_BITS_DEF,
    parameter int DISTANCE_BITS = pdh_pkg::DISTANCE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [pdh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdh_pkg::M_TDATA_W-1:0]      m_tdata,   // peak_back, peak_level
    output logic [0:0]                         m_tuser    // peak_found
);

    logic [pdh_pkg::CFG_DATA_W-1:0]                rise_reg;
    logic [pdh_pkg::CFG_DATA_W-1:0]                fall_reg;
    logic [pdh_pkg::CFG_DATA_W-1:0]                weight_reg;

    logic                                          in_valid_reg;
    logic [SAMPLE_BITS-1:0]                        sample_reg;
    logic                                          m_valid_reg;
    pdh_pkg::result_t                              res_reg;

    logic                                          fire;
    logic [SAMPLE_BITS+pdh_pkg::AVG_FRAC_BITS-1:0] avg;
    pdh_pkg::thresh_flags_t                        flags;
    pdh_pkg::result_t                              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg   <= pdh_pkg::RISE_FACTOR_RST;
            fall_reg   <= pdh_pkg::FALL_FACTOR_RST;
            weight_reg <= pdh_pkg::AVG_WEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (pdh_pkg::cfg_idx_t'(cfg_index))
                pdh_pkg::CFG_RISE_FACTOR: begin
                    rise_reg <= cfg_wdata;
                end
                pdh_pkg::CFG_FALL_FACTOR: begin
                    fall_reg <= cfg_wdata;
                end
                pdh_pkg::CFG_AVG_WEIGHT: begin
                    weight_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // The sample in the input register is processed when the result register
    // is free or being emptied in the same cycle.
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    pdh_avg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (fire),
        .sample  (sample_reg),
        .weight  (weight_reg),
        .avg     (avg)
    );

    pdh_thresh #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rise (
        .sample (sample_reg),
        .avg    (avg),
        .factor (rise_reg),
        .above  (flags.above_rise)
    );

    pdh_thresh #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fall (
        .sample (sample_reg),
        .avg    (avg),
        .factor (fall_reg),
        .above  (flags.above_fall)
    );

    pdh_track #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (fire),
        .sample  (sample_reg),
        .flags   (flags),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.level, res_reg.back};
    assign m_tuser  = res_reg.found;

endmodule

FILE: rtl/pdh_checker.sv
`timescale 1ns / 1ps

module pdh_checker #(
    parameter int S_TDATA_W = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [S_TDATA_W-1:0]          s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pdh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    localparam int BACK_W = pdh_pkg::BACK_W;

    // A result beat that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // With the result side draining, the block never pushes back on samples.
    a_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side was ready");

    // The distance field is only meaningful on a confirmed peak.
    a_back_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[BACK_W-1:0] == '0)
        else $error("distance reported without a confirmed peak");

    // A confirmed peak always lies at least one sample back.
    a_back_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[BACK_W-1:0] != '0)
        else $error("confirmed peak with zero distance");

    logic unused_ok;
    assign unused_ok = s_tvalid ^ (^s_tdata);

endmodule

bind peak_detector_hysteresis_unit pdh_checker #(
    .S_TDATA_W (((SAMPLE_BITS+7)/8)*8)
) u_pdh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
